>>> design/cltok_pkg.sv
// ----------------------------------------------------------------------------
// cltok_pkg
// Shared types, codes and byte classes for the command line tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cltok_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] CH_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DQUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SQUOTE    = 8'h27;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;

    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_UNQ    = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;

    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_LETTER_EXP   = 3'd1;
    localparam logic [2:0] ERR_BAD_WORD     = 3'd2;
    localparam logic [2:0] ERR_BAD_UNQ      = 3'd3;
    localparam logic [2:0] ERR_NO_CLOSE     = 3'd4;
    localparam logic [2:0] ERR_SPACE_EXP    = 3'd5;

    localparam logic FTW_RESET = 1'b1;

    typedef struct packed {
        logic [2:0]        error_code;
        logic [1:0]        token_kind;
        logic              line_end;
        logic              token_end;
        logic              has_byte;
        logic [BYTE_W-1:0] out_byte;
    } result_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_word_char(input logic [BYTE_W-1:0] c);
        return is_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_unquoted_char(input logic [BYTE_W-1:0] c);
        return (c > CH_SPACE) && (c != CH_DQUOTE) && (c != CH_SQUOTE);
    endfunction

endpackage

>>> design/cltok_lexer.sv
// ----------------------------------------------------------------------------
// cltok_lexer
// Lexer state machine and result register; takes one held byte per cycle unless a result waits on out_ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cltok_lexer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [cltok_pkg::BYTE_W-1:0]    in_byte,
    input  logic                            first_token_word,
    input  logic                            out_ready,
    output logic                            in_take,
    output logic                            out_valid,
    output cltok_pkg::result_t              out_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_WORD,
        PH_UNQ,
        PH_STR,
        PH_ESC,
        PH_QCLOSE,
        PH_SKIPWS,
        PH_DISCARD
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               seen_reg, seen_next;
    logic               out_valid_reg, out_valid_next;
    cltok_pkg::result_t result_reg;

    phase_t             bt_phase;
    logic               bt_emit;
    cltok_pkg::result_t bt_res;

    logic               emit;
    cltok_pkg::result_t res;
    logic               is_nul;

    assign is_nul = (in_byte == cltok_pkg::CH_NUL);

    // first byte of a token
    always_comb
    begin
        bt_emit  = 1'b1;
        bt_res   = '0;
        bt_phase = PH_DISCARD;
        if (!seen_reg && first_token_word)
        begin
            bt_res.token_kind = cltok_pkg::KIND_WORD;
            if (!cltok_pkg::is_alpha(in_byte))
            begin
                bt_res.error_code = cltok_pkg::ERR_LETTER_EXP;
            end
            else
            begin
                bt_phase        = PH_WORD;
                bt_res.out_byte = in_byte;
                bt_res.has_byte = 1'b1;
            end
        end
        else if (in_byte == cltok_pkg::CH_DQUOTE)
        begin
            bt_emit  = 1'b0;
            bt_phase = PH_STR;
        end
        else
        begin
            bt_res.token_kind = cltok_pkg::KIND_UNQ;
            if (!cltok_pkg::is_unquoted_char(in_byte))
            begin
                bt_res.error_code = cltok_pkg::ERR_BAD_UNQ;
            end
            else
            begin
                bt_phase        = PH_UNQ;
                bt_res.out_byte = in_byte;
                bt_res.has_byte = 1'b1;
            end
        end
    end

    always_comb
    begin
        emit       = 1'b0;
        res        = '0;
        phase_next = phase_reg;
        seen_next  = seen_reg;
        case (phase_reg)
            PH_START, PH_SKIPWS:
            begin
                if (is_nul)
                begin
                    emit         = 1'b1;
                    res.line_end = 1'b1;
                end
                else if ((phase_reg == PH_SKIPWS) && cltok_pkg::is_space(in_byte))
                begin
                    emit = 1'b0;
                end
                else
                begin
                    emit       = bt_emit;
                    res        = bt_res;
                    phase_next = bt_phase;
                    seen_next  = 1'b1;
                end
            end
            PH_WORD, PH_UNQ:
            begin
                emit           = 1'b1;
                res.token_kind = (phase_reg == PH_WORD) ? cltok_pkg::KIND_WORD
                                                        : cltok_pkg::KIND_UNQ;
                if (is_nul)
                begin
                    res.token_end = 1'b1;
                    res.line_end  = 1'b1;
                end
                else if (cltok_pkg::is_space(in_byte))
                begin
                    res.token_end = 1'b1;
                    phase_next    = PH_SKIPWS;
                end
                else if ((phase_reg == PH_WORD) && !cltok_pkg::is_word_char(in_byte))
                begin
                    res.error_code = cltok_pkg::ERR_BAD_WORD;
                    phase_next     = PH_DISCARD;
                end
                else if ((phase_reg == PH_UNQ) && !cltok_pkg::is_unquoted_char(in_byte))
                begin
                    res.error_code = cltok_pkg::ERR_BAD_UNQ;
                    phase_next     = PH_DISCARD;
                end
                else
                begin
                    res.out_byte = in_byte;
                    res.has_byte = 1'b1;
                end
            end
            PH_STR, PH_ESC:
            begin
                res.token_kind = cltok_pkg::KIND_STRING;
                if (is_nul)
                begin
                    emit           = 1'b1;
                    res.error_code = cltok_pkg::ERR_NO_CLOSE;
                    res.line_end   = 1'b1;
                end
                else if ((phase_reg == PH_STR) && (in_byte == cltok_pkg::CH_DQUOTE))
                begin
                    phase_next = PH_QCLOSE;
                end
                else if ((phase_reg == PH_STR) && (in_byte == cltok_pkg::CH_BACKSLASH))
                begin
                    phase_next = PH_ESC;
                end
                else
                begin
                    emit         = 1'b1;
                    res.out_byte = in_byte;
                    res.has_byte = 1'b1;
                    phase_next   = PH_STR;
                end
            end
            PH_QCLOSE:
            begin
                emit           = 1'b1;
                res.token_kind = cltok_pkg::KIND_STRING;
                if (is_nul)
                begin
                    res.token_end = 1'b1;
                    res.line_end  = 1'b1;
                end
                else if (cltok_pkg::is_space(in_byte))
                begin
                    res.token_end = 1'b1;
                    phase_next    = PH_SKIPWS;
                end
                else
                begin
                    res.error_code = cltok_pkg::ERR_SPACE_EXP;
                    phase_next     = PH_DISCARD;
                end
            end
            default:
            begin
                if (is_nul)
                begin
                    emit         = 1'b1;
                    res.line_end = 1'b1;
                end
            end
        endcase
        // line end rewinds to token start
        if (emit && res.line_end)
        begin
            phase_next = PH_START;
            seen_next  = 1'b0;
        end
    end

    // a byte that produces no result never waits on the output side
    assign in_take = in_valid && (!out_valid_reg || out_ready || !emit);

    always_comb
    begin
        if (in_take && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (in_take)
            begin
                phase_reg <= phase_next;
                seen_reg  <= seen_next;
                if (emit)
                begin
                    result_reg <= res;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

>>> design/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Path: a byte accepted on s_tdata passes through the input register, then
// the lexer logic into the result register that drives m_tvalid.
// Throughput: one byte per cycle while m_tready does not stall a result;
// a stalled result register holds one more byte in the input register.
// Reset: rst_n clears both stages, the lexer goes to token start with no
// token seen, and first_token_word returns to 1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module command_line_tokenizer (
    input  logic                          clk,
    input  logic                          rst_n,
    // input byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cltok_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    // token stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cltok_pkg::BYTE_W-1:0]  m_tdata,   // [7:0] out_byte
    output logic [6:0]                    m_tuser,   // [0] has_byte, [1] token_end,
                                                     // [3:2] token_kind, [6:4] error_code
    output logic                          m_tlast,   // line_end
    // configuration write: first_token_word
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    logic [cltok_pkg::BYTE_W-1:0]  in_byte_reg;
    logic                          ftw_reg;
    logic                          take;
    logic                          s_accept;
    logic                          res_valid;
    cltok_pkg::result_t            res;

    // configuration writes are always taken; the block is idle by contract
    assign cfg_ready = 1'b1;

    // the input stage frees itself whenever the lexer consumes its byte
    assign s_tready = !in_valid_reg || take;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (take)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            ftw_reg      <= cltok_pkg::FTW_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid)
            begin
                ftw_reg <= cfg_data;
            end
        end
    end

    // payload: hold while stalled, load on accept
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    cltok_lexer u_lexer (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid_reg),
        .in_byte          (in_byte_reg),
        .first_token_word (ftw_reg),
        .out_ready        (m_tready),
        .in_take          (take),
        .out_valid        (res_valid),
        .out_result       (res)
    );

    // pack the result onto the master side
    assign m_tvalid = res_valid;
    assign m_tdata  = res.out_byte;
    assign m_tuser  = {res.error_code, res.token_kind, res.token_end, res.has_byte};
    assign m_tlast  = res.line_end;

endmodule
